// ----- hw/rtl/uer_pkg.sv -----
// shared types, codes and constants of the echo ranger
package uer_pkg;

    localparam int unsigned NUM_CH          = 3;
    localparam int unsigned MAX_DISTANCE_CM = 400;
    localparam int unsigned HIST_MAX        = 511;
    localparam int unsigned DIST_CAP        =
        (MAX_DISTANCE_CM > HIST_MAX) ? HIST_MAX : MAX_DISTANCE_CM;
    localparam int unsigned QUEUE_DEPTH     = 4;

    localparam logic [1:0] ACT_ARM     = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_RISE    = 2'd2;
    localparam logic [1:0] ACT_FALL    = 2'd3;

    localparam logic [1:0] CH_RIGHT   = 2'd0;
    localparam logic [1:0] CH_CENTER  = 2'd1;
    localparam logic [1:0] CH_LEFT    = 2'd2;
    localparam logic [1:0] NO_CHANNEL = 2'd3;

    localparam logic [8:0]  DIST_CAP_CM   = 9'(DIST_CAP);
    localparam logic [8:0]  THRESH_RESET  = 9'd20;
    localparam logic [36:0] CM_PER_US_MUL = 37'd17;
    // width*17 at or above this saturates
    localparam logic [36:0] SAT_LIMIT     = 37'((DIST_CAP + 1) * 1000);
    // ceil(2^24 / 125), exact floor division of a 16-bit value by 125
    localparam logic [33:0] RECIP_125     = 34'd134218;

    typedef struct packed {
        logic        wr;
        logic [1:0]  ch;
        logic [31:0] width;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic        wr;
        logic [1:0]  ch;
        logic [36:0] prod;
    } stage_a_t;

    typedef struct packed {
        logic       wr;
        logic [1:0] ch;
        logic [8:0] dist_cm;
    } stage_b_t;

endpackage

// ----- hw/rtl/uer_if.sv -----
// event and report channel interfaces of the echo ranger
interface uer_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  channel;
    logic [31:0] timestamp_us;

    modport source (output valid, action, channel, timestamp_us, input ready);
    modport sink   (input valid, action, channel, timestamp_us, output ready);
endinterface

interface uer_rpt_if;
    logic       valid;
    logic       ready;
    logic [8:0] dist_right;
    logic [8:0] dist_center;
    logic [8:0] dist_left;
    logic       obstacle_right;
    logic       obstacle_center;
    logic       obstacle_left;
    logic       all_blocked;
    logic       valid_right;
    logic       valid_center;
    logic       valid_left;

    modport source (output valid, dist_right, dist_center, dist_left, obstacle_right,
                    obstacle_center, obstacle_left, all_blocked, valid_right,
                    valid_center, valid_left, input ready);
    modport sink   (input valid, dist_right, dist_center, dist_left, obstacle_right,
                    obstacle_center, obstacle_left, all_blocked, valid_right,
                    valid_center, valid_left, output ready);
endinterface

// ----- hw/rtl/uer_front.sv -----
// front end: event intake, arming state, rise capture and width computation
module uer_front
(
    input  logic              clk,
    input  logic              rst_n,
    uer_evt_if.sink           evt,
    input  uer_pkg::q_stat_t  q_stat,
    output logic              q_push,
    output uer_pkg::cmd_t     q_wdata
);

    logic [1:0]  armed_ch_reg;
    logic [1:0]  armed_ch_next;
    logic [31:0] rise_time_reg [uer_pkg::NUM_CH];
    logic [31:0] rise_sel;
    logic        accept;
    logic        is_edge;
    logic        hit;

    assign evt.ready = !q_stat.full;
    assign accept    = evt.valid && evt.ready;
    assign is_edge   = (evt.action == uer_pkg::ACT_RISE) || (evt.action == uer_pkg::ACT_FALL);
    assign hit       = is_edge && (evt.channel != uer_pkg::NO_CHANNEL)
                       && (evt.channel == armed_ch_reg);

    always_comb
    begin
        case (evt.channel)
            uer_pkg::CH_RIGHT:  rise_sel = rise_time_reg[0];
            uer_pkg::CH_CENTER: rise_sel = rise_time_reg[1];
            uer_pkg::CH_LEFT:   rise_sel = rise_time_reg[2];
            default:            rise_sel = '0;
        endcase
    end

    always_comb
    begin
        case (evt.action)
            uer_pkg::ACT_ARM:     armed_ch_next = evt.channel;
            uer_pkg::ACT_RELEASE: armed_ch_next = uer_pkg::NO_CHANNEL;
            default:              armed_ch_next = armed_ch_reg;
        endcase
    end

    assign q_push        = accept;
    assign q_wdata.wr    = hit && (evt.action == uer_pkg::ACT_FALL);
    assign q_wdata.ch    = evt.channel;
    assign q_wdata.width = evt.timestamp_us - rise_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_ch_reg <= uer_pkg::NO_CHANNEL;
            for (int c = 0; c < uer_pkg::NUM_CH; c++)
            begin
                rise_time_reg[c] <= '0;
            end
        end
        else if (accept)
        begin
            armed_ch_reg <= armed_ch_next;
            for (int c = 0; c < uer_pkg::NUM_CH; c++)
            begin
                if (hit && (evt.action == uer_pkg::ACT_RISE) && (evt.channel == 2'(c)))
                begin
                    rise_time_reg[c] <= evt.timestamp_us;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/uer_fifo.sv -----
// command queue between front and back end
module uer_fifo
#(
    parameter int unsigned DEPTH = uer_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  uer_pkg::cmd_t     wdata,
    input  logic              pop,
    output uer_pkg::cmd_t     rdata,
    output uer_pkg::q_stat_t  stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    uer_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/uer_back.sv -----
// back end: distance conversion, median history and report register
module uer_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [8:0]        cfg_wr_data,
    input  uer_pkg::q_stat_t  q_stat,
    input  uer_pkg::cmd_t     q_rdata,
    output logic              q_pop,
    uer_rpt_if.source         rpt
);

    function automatic logic [8:0] med3(logic [8:0] a, logic [8:0] b, logic [8:0] c);
        logic [8:0] lo;
        logic [8:0] hi;
        logic [8:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    logic [8:0]          threshold_reg;
    logic                adv;
    logic                a_valid_reg;
    logic                b_valid_reg;
    logic                rpt_valid_reg;
    uer_pkg::stage_a_t   a_reg;
    uer_pkg::stage_b_t   b_reg;
    uer_pkg::stage_b_t   b_next;
    logic                sat;
    logic [33:0]         quo_prod;
    logic [8:0]          hist_reg  [uer_pkg::NUM_CH][3];
    logic [8:0]          hist_next [uer_pkg::NUM_CH][3];
    logic [1:0]          ring_reg  [uer_pkg::NUM_CH];
    logic [1:0]          ring_next [uer_pkg::NUM_CH];
    logic                meas_reg  [uer_pkg::NUM_CH];
    logic                meas_next [uer_pkg::NUM_CH];
    logic [8:0]          med       [uer_pkg::NUM_CH];
    logic                obs       [uer_pkg::NUM_CH];
    logic [8:0]          dist_reg  [uer_pkg::NUM_CH];
    logic                obs_reg   [uer_pkg::NUM_CH];
    logic                vld_reg   [uer_pkg::NUM_CH];
    logic                blocked_reg;

    assign adv   = !rpt_valid_reg || rpt.ready;
    assign q_pop = adv && !q_stat.empty;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= uer_pkg::THRESH_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
        end
    end

    // distance conversion with saturation
    assign sat      = (a_reg.prod >= uer_pkg::SAT_LIMIT);
    assign quo_prod = 34'(a_reg.prod[18:3]) * uer_pkg::RECIP_125;

    always_comb
    begin
        b_next.wr      = a_reg.wr;
        b_next.ch      = a_reg.ch;
        b_next.dist_cm = sat ? uer_pkg::DIST_CAP_CM : quo_prod[32:24];
    end

    always_comb
    begin
        for (int c = 0; c < uer_pkg::NUM_CH; c++)
        begin
            ring_next[c] = ring_reg[c];
            meas_next[c] = meas_reg[c];
            for (int k = 0; k < 3; k++)
            begin
                hist_next[c][k] = hist_reg[c][k];
            end
            if (b_valid_reg && b_reg.wr && (b_reg.ch == 2'(c)))
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if ((ring_reg[c] == 2'(k)) || ((ring_reg[c] == 2'd3) && (k == 0)))
                    begin
                        hist_next[c][k] = b_reg.dist_cm;
                    end
                end
                ring_next[c] = (ring_reg[c] == 2'd1) ? 2'd2 :
                               (ring_reg[c] == 2'd0) ? 2'd1 : 2'd0;
                meas_next[c] = 1'b1;
            end
            med[c] = med3(hist_next[c][0], hist_next[c][1], hist_next[c][2]);
            obs[c] = (med[c] < threshold_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            rpt_valid_reg <= 1'b0;
            blocked_reg   <= 1'b0;
            for (int c = 0; c < uer_pkg::NUM_CH; c++)
            begin
                ring_reg[c] <= '0;
                meas_reg[c] <= 1'b0;
                dist_reg[c] <= uer_pkg::DIST_CAP_CM;
                obs_reg[c]  <= 1'b0;
                vld_reg[c]  <= 1'b0;
                for (int k = 0; k < 3; k++)
                begin
                    hist_reg[c][k] <= uer_pkg::DIST_CAP_CM;
                end
            end
        end
        else if (adv)
        begin
            a_valid_reg   <= !q_stat.empty;
            b_valid_reg   <= a_valid_reg;
            rpt_valid_reg <= b_valid_reg;
            if (b_valid_reg)
            begin
                blocked_reg <= obs[0] && obs[1] && obs[2];
                for (int c = 0; c < uer_pkg::NUM_CH; c++)
                begin
                    ring_reg[c] <= ring_next[c];
                    meas_reg[c] <= meas_next[c];
                    dist_reg[c] <= med[c];
                    obs_reg[c]  <= obs[c];
                    vld_reg[c]  <= meas_next[c];
                    for (int k = 0; k < 3; k++)
                    begin
                        hist_reg[c][k] <= hist_next[c][k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg.wr   <= q_rdata.wr;
            a_reg.ch   <= q_rdata.ch;
            a_reg.prod <= {5'b0, q_rdata.width} * uer_pkg::CM_PER_US_MUL;
            b_reg      <= b_next;
        end
    end

    assign rpt.valid           = rpt_valid_reg;
    assign rpt.dist_right      = dist_reg[0];
    assign rpt.dist_center     = dist_reg[1];
    assign rpt.dist_left       = dist_reg[2];
    assign rpt.obstacle_right  = obs_reg[0];
    assign rpt.obstacle_center = obs_reg[1];
    assign rpt.obstacle_left   = obs_reg[2];
    assign rpt.all_blocked     = blocked_reg;
    assign rpt.valid_right     = vld_reg[0];
    assign rpt.valid_center    = vld_reg[1];
    assign rpt.valid_left      = vld_reg[2];

endmodule

// ----- hw/rtl/ultrasonic_echo_ranger_median.sv -----
// Three-channel ultrasonic echo ranger with median-of-three filtering. Each event item
// (arm, release, echo rise, echo fall with a microsecond timestamp) is taken at up to
// one item per cycle while the command queue is not full and gives one report item: per
// channel the median of the last three distances in cm, an obstacle flag (median below
// the threshold register) and a valid flag, plus an all-blocked flag. Events pass the
// command queue and the back-end pipeline (multiply by 17, divide by 1000 with saturation,
// history update and median); QUEUE_DEPTH queue entries let events keep coming while
// reports are stalled. The threshold register resets to 20 cm and is written through
// cfg_wr_en / cfg_wr_data; the user must write only while the block is idle (not enforced).
module ultrasonic_echo_ranger_median
#(
    parameter int unsigned QUEUE_DEPTH = uer_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    uer_evt_if.sink     evt,
    uer_rpt_if.source   rpt
);

    uer_pkg::q_stat_t q_stat;
    uer_pkg::cmd_t    q_wdata;
    uer_pkg::cmd_t    q_rdata;
    logic             q_push;
    logic             q_pop;

    uer_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    uer_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    uer_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_stat      (q_stat),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .rpt         (rpt)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command queue overflow");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (rpt.valid && rpt.ready && rpt.valid_right) |=> (!rpt.valid || rpt.valid_right))
        else $error("right valid flag dropped");

    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rpt.valid |-> (rpt.dist_right <= uer_pkg::DIST_CAP_CM)
                   && (rpt.dist_center <= uer_pkg::DIST_CAP_CM)
                   && (rpt.dist_left <= uer_pkg::DIST_CAP_CM))
        else $error("distance above cap");

    a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        rpt.valid |-> (rpt.all_blocked
                       == (rpt.obstacle_right && rpt.obstacle_center && rpt.obstacle_left)))
        else $error("all_blocked inconsistent with obstacle flags");
`endif

endmodule

// ----- bench/tb_ultrasonic_echo_ranger_median.sv -----
// self-checking testbench for the three-channel echo ranger with median filter
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_median;

    typedef struct packed {
        logic [8:0] dist_right;
        logic [8:0] dist_center;
        logic [8:0] dist_left;
        logic       obstacle_right;
        logic       obstacle_center;
        logic       obstacle_left;
        logic       all_blocked;
        logic       valid_right;
        logic       valid_center;
        logic       valid_left;
    } report_t;

    typedef struct packed {
        logic [1:0]  act;
        logic [1:0]  ch;
        logic [31:0] ts;
        logic        fixed;
        report_t     want;
    } directed_row_t;

    localparam report_t IDLE_REPORT = '{uer_pkg::DIST_CAP_CM, uer_pkg::DIST_CAP_CM,
                                        uer_pkg::DIST_CAP_CM,
                                        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam int N_DIRECTED = 25;
    localparam int PHASE_ITEMS = 265;
    localparam int HOLD_CYCLES = 400;

    localparam directed_row_t DIRECTED [N_DIRECTED] = '{
        '{uer_pkg::ACT_RELEASE, uer_pkg::CH_RIGHT,   32'h0000_0000, 1'b1, IDLE_REPORT},
        '{uer_pkg::ACT_RISE,    uer_pkg::CH_RIGHT,   32'hFFFF_FFFF, 1'b1, IDLE_REPORT},
        '{uer_pkg::ACT_FALL,    uer_pkg::CH_CENTER,  32'hFFFF_FFFF, 1'b1, IDLE_REPORT},
        '{uer_pkg::ACT_ARM,     uer_pkg::NO_CHANNEL, 32'h0000_0000, 1'b1, IDLE_REPORT},
        '{uer_pkg::ACT_RISE,    uer_pkg::NO_CHANNEL, 32'h1234_5678, 1'b1, IDLE_REPORT},
        '{uer_pkg::ACT_FALL,    uer_pkg::NO_CHANNEL, 32'hFFFF_FFFF, 1'b1, IDLE_REPORT},
        '{uer_pkg::ACT_ARM,     uer_pkg::CH_RIGHT,   32'h0000_0000, 1'b1, IDLE_REPORT},
        // fall with no rise since reset
        '{uer_pkg::ACT_FALL,    uer_pkg::CH_RIGHT,   32'h0000_0000, 1'b0, '0},
        // width wraps through zero
        '{uer_pkg::ACT_RISE,    uer_pkg::CH_RIGHT,   32'hFFFF_FFF0, 1'b0, '0},
        '{uer_pkg::ACT_FALL,    uer_pkg::CH_RIGHT,   32'h0000_0010, 1'b0, '0},
        // widest pulse saturates
        '{uer_pkg::ACT_RISE,    uer_pkg::CH_RIGHT,   32'h0000_0000, 1'b0, '0},
        '{uer_pkg::ACT_FALL,    uer_pkg::CH_RIGHT,   32'hFFFF_FFFF, 1'b0, '0},
        '{uer_pkg::ACT_ARM,     uer_pkg::CH_CENTER,  32'h0000_0005, 1'b0, '0},
        '{uer_pkg::ACT_RISE,    uer_pkg::CH_LEFT,    32'h0000_0064, 1'b0, '0},
        '{uer_pkg::ACT_RISE,    uer_pkg::CH_CENTER,  32'd1000,      1'b0, '0},
        '{uer_pkg::ACT_FALL,    uer_pkg::CH_CENTER,  32'd24529,     1'b0, '0},
        '{uer_pkg::ACT_RISE,    uer_pkg::CH_CENTER,  32'd0,         1'b0, '0},
        '{uer_pkg::ACT_FALL,    uer_pkg::CH_CENTER,  32'd23530,     1'b0, '0},
        // second fall reuses the stored rise time
        '{uer_pkg::ACT_FALL,    uer_pkg::CH_CENTER,  32'd23589,     1'b0, '0},
        '{uer_pkg::ACT_ARM,     uer_pkg::CH_LEFT,    32'h0000_0000, 1'b0, '0},
        '{uer_pkg::ACT_RISE,    uer_pkg::CH_LEFT,    32'h7FFF_FFFF, 1'b0, '0},
        '{uer_pkg::ACT_FALL,    uer_pkg::CH_LEFT,    32'h8000_0000, 1'b0, '0},
        '{uer_pkg::ACT_ARM,     uer_pkg::CH_RIGHT,   32'h0000_0000, 1'b0, '0},
        '{uer_pkg::ACT_RELEASE, uer_pkg::CH_LEFT,    32'h0000_0000, 1'b0, '0},
        '{uer_pkg::ACT_FALL,    uer_pkg::CH_RIGHT,   32'h0000_0005, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [8:0] cfg_wr_data;

    uer_evt_if evt_if ();
    uer_rpt_if rpt_if ();

    ultrasonic_echo_ranger_median DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .evt         (evt_if),
        .rpt         (rpt_if)
    );

    // predictor state
    logic [1:0]  armed_ch;
    logic [31:0] rise_ts [3];
    logic [8:0]  ring [3][3];
    logic [1:0]  ring_wr [3];
    logic [2:0]  measured;
    logic [8:0]  thresh;

    report_t     pending_reports [$];
    report_t     seen;
    report_t     want;
    int          events_sent = 0;
    int          mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_go = 1'b0;
    int          hold_left = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [8:0] median3(input logic [8:0] a, input logic [8:0] b,
                                           input logic [8:0] c);
        logic [8:0] lo;
        logic [8:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (c < lo) ? lo : ((c > hi) ? hi : c);
    endfunction

    function automatic report_t track_event(input logic [1:0] act, input logic [1:0] ch,
                                            input logic [31:0] ts);
        logic [31:0]     echo_width;
        longint unsigned span_cm;
        logic [8:0]      med [3];
        report_t         r;
        if (act == uer_pkg::ACT_ARM)
        begin
            armed_ch = ch;
        end
        else if (act == uer_pkg::ACT_RELEASE)
        begin
            armed_ch = uer_pkg::NO_CHANNEL;
        end
        else if (ch != uer_pkg::NO_CHANNEL && ch == armed_ch)
        begin
            if (act == uer_pkg::ACT_RISE)
            begin
                rise_ts[ch] = ts;
            end
            else
            begin
                echo_width = ts - rise_ts[ch];
                span_cm = (echo_width * 64'd17) / 64'd1000;
                if (span_cm > uer_pkg::DIST_CAP)
                begin
                    span_cm = uer_pkg::DIST_CAP;
                end
                ring[ch][ring_wr[ch]] = 9'(span_cm);
                ring_wr[ch] = (ring_wr[ch] == 2'd2) ? 2'd0 : ring_wr[ch] + 2'd1;
                measured[ch] = 1'b1;
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            med[c] = median3(ring[c][0], ring[c][1], ring[c][2]);
        end
        r.dist_right      = med[0];
        r.dist_center     = med[1];
        r.dist_left       = med[2];
        r.obstacle_right  = med[0] < thresh;
        r.obstacle_center = med[1] < thresh;
        r.obstacle_left   = med[2] < thresh;
        r.all_blocked     = r.obstacle_right & r.obstacle_center & r.obstacle_left;
        r.valid_right     = measured[0];
        r.valid_center    = measured[1];
        r.valid_left      = measured[2];
        return r;
    endfunction

    function automatic string show(input report_t r);
        return $sformatf("dist %0d/%0d/%0d obst %b%b%b blk %b meas %b%b%b",
                         r.dist_right, r.dist_center, r.dist_left, r.obstacle_right,
                         r.obstacle_center, r.obstacle_left, r.all_blocked,
                         r.valid_right, r.valid_center, r.valid_left);
    endfunction

    task automatic log_failure(input string what, input report_t exp_r, input report_t got_r);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t %s: expected %s, got %s", $realtime, what, show(exp_r),
                     show(got_r));
        end
    endtask

    task automatic send_event(input logic [1:0] act, input logic [1:0] ch,
                              input logic [31:0] ts, input logic fixed = 1'b0,
                              input report_t fixed_rpt = '0);
        report_t predicted;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            evt_if.valid <= 1'b0;
            @(posedge clk);
        end
        evt_if.valid        <= 1'b1;
        evt_if.action       <= act;
        evt_if.channel      <= ch;
        evt_if.timestamp_us <= ts;
        do
            @(posedge clk);
        while (evt_if.ready !== 1'b1);
        predicted = track_event(act, ch, ts);
        pending_reports.push_back(fixed ? fixed_rpt : predicted);
        events_sent++;
    endtask

    task automatic random_events(input int upto);
        logic [1:0]  ch;
        logic [31:0] t0;
        logic [31:0] span;
        int unsigned kind;
        while (events_sent < upto)
        begin
            if ($urandom_range(99, 0) < 15)
            begin
                send_event(2'($urandom_range(3, 0)), 2'($urandom_range(3, 0)), $urandom);
            end
            else
            begin
                ch = 2'($urandom_range(2, 0));
                t0 = $urandom;
                kind = $urandom_range(9, 0);
                if (kind < 4)
                    span = 32'($urandom_range(2000, 0));
                else if (kind < 7)
                    span = 32'($urandom_range(23600, 0));
                else if (kind < 9)
                    span = 32'($urandom_range(23600, 23500));
                else
                    span = $urandom;
                send_event(uer_pkg::ACT_ARM, ch, $urandom);
                if ($urandom_range(7, 0) != 0)
                begin
                    send_event(uer_pkg::ACT_RISE, ch, t0);
                end
                if ($urandom_range(5, 0) == 0)
                begin
                    send_event(uer_pkg::ACT_RISE, 2'($urandom_range(3, 0)), $urandom);
                end
                send_event(uer_pkg::ACT_FALL, ch, t0 + span);
                if ($urandom_range(3, 0) == 0)
                begin
                    send_event(uer_pkg::ACT_RELEASE, 2'($urandom_range(3, 0)), $urandom);
                end
            end
        end
    endtask

    task automatic drain_reports();
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_threshold(input logic [8:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        thresh = value;
    endtask

    // receiver stall counter
    always @(posedge clk)
    begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        rpt_if.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rpt_if.valid === 1'b1 && rpt_if.ready === 1'b1)
        begin
            seen = '{rpt_if.dist_right, rpt_if.dist_center, rpt_if.dist_left,
                     rpt_if.obstacle_right, rpt_if.obstacle_center, rpt_if.obstacle_left,
                     rpt_if.all_blocked, rpt_if.valid_right, rpt_if.valid_center,
                     rpt_if.valid_left};
            if (pending_reports.size() == 0)
            begin
                log_failure("unexpected report item", '0, seen);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (seen !== want)
                begin
                    log_failure("report mismatch", want, seen);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("ultrasonic_echo_ranger_median regression: fail");
        $finish;
    end

    initial
    begin
        int p;
        logic [8:0] phase_thresh [5];
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        evt_if.valid        = 1'b0;
        evt_if.action       = uer_pkg::ACT_ARM;
        evt_if.channel      = uer_pkg::CH_RIGHT;
        evt_if.timestamp_us = '0;
        armed_ch = uer_pkg::NO_CHANNEL;
        measured = '0;
        thresh   = uer_pkg::THRESH_RESET;
        for (int c = 0; c < 3; c++)
        begin
            rise_ts[c] = '0;
            ring_wr[c] = '0;
            for (int k = 0; k < 3; k++)
            begin
                ring[c][k] = uer_pkg::DIST_CAP_CM;
            end
        end
        phase_thresh = '{9'd0, 9'd511, 9'($urandom_range(511, 0)), 9'd200,
                         uer_pkg::THRESH_RESET};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 53;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_event(DIRECTED[i].act, DIRECTED[i].ch, DIRECTED[i].ts, DIRECTED[i].fixed,
                       DIRECTED[i].want);
        end
        evt_if.valid <= 1'b0;

        for (p = 0; p < 5; p++)
        begin
            drain_reports();
            write_threshold(phase_thresh[p]);
            send_idle_pct = (p < 2) ? 32 : ((p < 4) ? 53 : 0);
            recv_idle_pct = (p < 2) ? 53 : ((p < 4) ? 32 : 0);
            if (p == 1 || p == 3)
            begin
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            random_events(N_DIRECTED + (p + 1) * PHASE_ITEMS);
            evt_if.valid <= 1'b0;
        end

        drain_reports();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ultrasonic_echo_ranger_median regression: pass");
        else
            $display("ultrasonic_echo_ranger_median regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/uer_pkg.sv
hw/rtl/uer_if.sv
hw/rtl/uer_front.sv
hw/rtl/uer_fifo.sv
hw/rtl/uer_back.sv
hw/rtl/ultrasonic_echo_ranger_median.sv
bench/tb_ultrasonic_echo_ranger_median.sv
